@@ design/bba_pkg.sv @@
// Shared types and constants for the bitmap block allocator.
package bba_pkg;

  localparam int BLOCK_W           = 10;    // width of a block number field
  localparam int BLOCK_SPAN        = 1024;  // blocks a block number field can name
  localparam int OFF_W             = 6;     // bit offset within a map word (words up to 64 bits)
  localparam int FDB_RESET         = 64;    // first data block after reset
  localparam int DEF_TOTAL_BLOCKS  = 1024;
  localparam int DEF_MAP_WORD_BITS = 64;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_MARK  = 2'd2,
    OP_QUERY = 2'd3
  } opcode_t;

  // Control from the sequencer to the word unit
  typedef struct packed {
    opcode_t            op;
    logic               first;  // word holding the first data block
    logic               last;   // last word of the map
    logic [OFF_W-1:0]   off;    // target bit, or first data bit on the first word
  } scan_ctrl_t;

  // Status from the word unit back to the sequencer
  typedef struct packed {
    logic               hit;       // allocate found a free bit in this word
    logic [OFF_W-1:0]   idx;       // lowest free bit in range
    logic               bit_used;  // state of the target bit
  } scan_res_t;

endpackage

@@ design/bba_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module bba_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/bba_word_unit.sv @@
// Map word unit: first-free search with range masking, and bit set/clear/test.
module bba_word_unit
  import bba_pkg::*;
#(
  parameter int WORD_BITS = DEF_MAP_WORD_BITS,
  parameter int LAST_BITS = DEF_MAP_WORD_BITS
) (
  input  scan_ctrl_t           ctrl,
  input  logic [WORD_BITS-1:0] rd_word,
  output scan_res_t            res,
  output logic [WORD_BITS-1:0] wr_word
);

  logic [WORD_BITS-1:0] cand;

  always_comb begin
    for (int j = 0; j < WORD_BITS; j++) begin
      cand[j] = !rd_word[j]
              && (!ctrl.first || (OFF_W'(j) >= ctrl.off))
              && (!ctrl.last  || (j < LAST_BITS));
    end
  end

  // lowest candidate wins
  always_comb begin
    res.hit      = 1'b0;
    res.idx      = '0;
    res.bit_used = 1'b0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (cand[j]) begin
        res.hit = 1'b1;
        res.idx = OFF_W'(j);
      end
    end
    for (int j = 0; j < WORD_BITS; j++) begin
      if (OFF_W'(j) == ctrl.off) begin
        res.bit_used = rd_word[j];
      end
    end
  end

  always_comb begin
    for (int j = 0; j < WORD_BITS; j++) begin
      case (ctrl.op)
        OP_ALLOC: wr_word[j] = rd_word[j] | (res.hit && (OFF_W'(j) == res.idx));
        OP_FREE:  wr_word[j] = rd_word[j] & (OFF_W'(j) != ctrl.off);
        OP_MARK:  wr_word[j] = rd_word[j] | (OFF_W'(j) == ctrl.off);
        default:  wr_word[j] = rd_word[j];
      endcase
    end
  end

endmodule

@@ design/bitmap_block_allocator_core.sv @@
// Top level: first-fit bitmap block allocator with map RAM and word sequencer.
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+-----------------------------------------------
//  in_     | in  | in_tvalid / in_tready | tuser: opcode; tdata: block_number
//  out_    | out | out_tvalid/out_tready | tdata: result_block, found, block_free
//  cfg_    | in  | cfg_valid / cfg_ready | cfg_data: first_data_block
//
//  Free, mark and query read the map word from RAM, then modify/write it; allocate
//  reads map words in turn from the first data block's word until a free bit is found
//  or the last map word is examined, using the map RAM's single read port, one word per cycle.
//  After reset a clearing pass zeroes the map (16 words by default), one word a cycle;
//  in_tready stays low meanwhile.
//  A new item is taken in the cycle the previous result is taken, or later.
module bitmap_block_allocator_core
  import bba_pkg::*;
#(
  parameter int TOTAL_BLOCKS  = DEF_TOTAL_BLOCKS,
  parameter int MAP_WORD_BITS = DEF_MAP_WORD_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  // input items
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [15:0]        in_tdata,   // [9:0] block_number, rest zero
  input  logic [1:0]         in_tuser,   // [1:0] opcode
  // result items
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [15:0]        out_tdata,  // [9:0] result_block, [10] found, [11] block_free
  // first data block register
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [BLOCK_W-1:0] cfg_data
);

  // only blocks a block number can name are ever touched
  localparam int EFF       = (TOTAL_BLOCKS < BLOCK_SPAN) ? TOTAL_BLOCKS : BLOCK_SPAN;
  localparam int WORDS     = (EFF + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int AW        = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int LAST_BITS = EFF - (WORDS - 1) * MAP_WORD_BITS;
  localparam int BASE_W    = BLOCK_W + 1;
  localparam int DIV_K     = 17;
  localparam int RECIP     = ((1 << DIV_K) + MAP_WORD_BITS - 1) / MAP_WORD_BITS;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK
  } state_t;

  // block number -> {word index, bit offset}, by reciprocal multiply
  function automatic logic [AW+OFF_W-1:0] split_blk(input logic [BLOCK_W-1:0] b);
    logic [31:0] prod;
    logic [31:0] q;
    logic [31:0] r;
    prod = 32'(b) * 32'(RECIP);
    q    = prod >> DIV_K;
    r    = 32'(b) - q * 32'(MAP_WORD_BITS);
    if (r >= 32'(MAP_WORD_BITS)) begin
      q = q + 32'd1;
      r = r - 32'(MAP_WORD_BITS);
    end
    return {q[AW-1:0], r[OFF_W-1:0]};
  endfunction

  state_t                   state_r, state_nxt;
  logic [AW-1:0]            clr_r, clr_nxt;
  logic [AW-1:0]            w_r, w_nxt;
  logic [BASE_W-1:0]        base_r, base_nxt;
  logic                     first_r, first_nxt;
  opcode_t                  op_r, op_nxt;
  logic [BLOCK_W-1:0]       blk_r, blk_nxt;
  logic [OFF_W-1:0]         off_r, off_nxt;
  logic [BLOCK_W-1:0]       fdb_r, fdb_nxt;
  logic [AW-1:0]            fdb_word_r, fdb_word_nxt;
  logic [OFF_W-1:0]         fdb_off_r, fdb_off_nxt;
  logic                     fdb_hi_r, fdb_hi_nxt;
  logic                     out_tvalid_r, out_tvalid_nxt;
  logic [BLOCK_W-1:0]       out_block_r, out_block_nxt;
  logic                     out_found_r, out_found_nxt;
  logic                     out_free_r, out_free_nxt;

  logic                     in_fire;
  opcode_t                  in_op;
  logic [BLOCK_W-1:0]       in_blk;
  logic [AW+OFF_W-1:0]      in_split;
  logic [AW+OFF_W-1:0]      cfg_split;

  logic                     ram_we, ram_re;
  logic [AW-1:0]            ram_waddr, ram_raddr;
  logic [MAP_WORD_BITS-1:0] ram_wdata, ram_rdata, unit_word;
  scan_ctrl_t               ctrl;
  scan_res_t                sres;
  logic                     last_word;

  assign in_op     = opcode_t'(in_tuser);
  assign in_blk    = in_tdata[BLOCK_W-1:0];
  assign in_split  = split_blk(in_blk);
  assign cfg_split = split_blk(cfg_data);
  assign in_tready = (state_r == ST_IDLE) && (!out_tvalid_r || out_tready);
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {4'b0, out_free_r, out_found_r, out_block_r};

  assign last_word  = (w_r == AW'(WORDS - 1));
  assign ctrl.op    = op_r;
  assign ctrl.first = first_r;
  assign ctrl.last  = last_word;
  assign ctrl.off   = off_r;

  bba_ram #(
    .WIDTH (MAP_WORD_BITS),
    .DEPTH (WORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bba_word_unit #(
    .WORD_BITS (MAP_WORD_BITS),
    .LAST_BITS (LAST_BITS)
  ) u_unit (
    .ctrl    (ctrl),
    .rd_word (ram_rdata),
    .res     (sres),
    .wr_word (unit_word)
  );

  // configuration: the word and offset of the first data block are kept split
  always_comb begin
    fdb_nxt      = fdb_r;
    fdb_word_nxt = fdb_word_r;
    fdb_off_nxt  = fdb_off_r;
    fdb_hi_nxt   = fdb_hi_r;
    if (cfg_valid && cfg_ready) begin
      fdb_nxt      = cfg_data;
      fdb_word_nxt = cfg_split[AW+OFF_W-1:OFF_W];
      fdb_off_nxt  = cfg_split[OFF_W-1:0];
      fdb_hi_nxt   = (BASE_W'(cfg_data) >= BASE_W'(EFF));
    end
  end

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    w_nxt          = w_r;
    base_nxt       = base_r;
    first_nxt      = first_r;
    op_nxt         = op_r;
    blk_nxt        = blk_r;
    off_nxt        = off_r;
    out_tvalid_nxt = out_tvalid_r;
    out_block_nxt  = out_block_r;
    out_found_nxt  = out_found_r;
    out_free_nxt   = out_free_r;
    ram_we         = 1'b0;
    ram_waddr      = w_r;
    ram_wdata      = unit_word;
    ram_re         = 1'b0;
    ram_raddr      = w_r;

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        if (clr_r == AW'(WORDS - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_nxt = clr_r + AW'(1);
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          op_nxt  = in_op;
          blk_nxt = in_blk;
          if (in_op == OP_ALLOC) begin
            if (fdb_hi_r) begin
              // nothing at or above the first data block
              out_tvalid_nxt = 1'b1;
              out_block_nxt  = '0;
              out_found_nxt  = 1'b0;
              out_free_nxt   = 1'b0;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = fdb_word_r;
              w_nxt     = fdb_word_r;
              off_nxt   = fdb_off_r;
              base_nxt  = BASE_W'(fdb_r) - BASE_W'(fdb_off_r);
              first_nxt = 1'b1;
              state_nxt = ST_CHECK;
            end
          end else if (BASE_W'(in_blk) >= BASE_W'(EFF)) begin
            // outside the map: counts as used, never changes
            out_tvalid_nxt = 1'b1;
            out_block_nxt  = in_blk;
            out_found_nxt  = 1'b0;
            out_free_nxt   = 1'b0;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = in_split[AW+OFF_W-1:OFF_W];
            w_nxt     = in_split[AW+OFF_W-1:OFF_W];
            off_nxt   = in_split[OFF_W-1:0];
            first_nxt = 1'b0;
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if ((op_r == OP_ALLOC) && !sres.hit && !last_word) begin
          ram_re    = 1'b1;
          ram_raddr = w_r + AW'(1);
          w_nxt     = w_r + AW'(1);
          base_nxt  = base_r + BASE_W'(MAP_WORD_BITS);
          first_nxt = 1'b0;
        end else begin
          ram_we         = (op_r == OP_ALLOC) ? sres.hit : (op_r != OP_QUERY);
          out_tvalid_nxt = 1'b1;
          out_found_nxt  = (op_r == OP_ALLOC) && sres.hit;
          out_free_nxt   = (op_r == OP_QUERY) && !sres.bit_used;
          if (op_r == OP_ALLOC) begin
            out_block_nxt = sres.hit ? BLOCK_W'(base_r + BASE_W'(sres.idx)) : '0;
          end else begin
            out_block_nxt = blk_r;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_r        <= '0;
      out_tvalid_r <= 1'b0;
      fdb_r        <= BLOCK_W'(FDB_RESET);
      fdb_word_r   <= AW'(FDB_RESET / MAP_WORD_BITS);
      fdb_off_r    <= OFF_W'(FDB_RESET % MAP_WORD_BITS);
      fdb_hi_r     <= (FDB_RESET >= EFF);
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      fdb_r        <= fdb_nxt;
      fdb_word_r   <= fdb_word_nxt;
      fdb_off_r    <= fdb_off_nxt;
      fdb_hi_r     <= fdb_hi_nxt;
    end
    w_r         <= w_nxt;
    base_r      <= base_nxt;
    first_r     <= first_nxt;
    op_r        <= op_nxt;
    blk_r       <= blk_nxt;
    off_r       <= off_nxt;
    out_block_r <= out_block_nxt;
    out_found_r <= out_found_nxt;
    out_free_r  <= out_free_nxt;
  end

`ifndef SYNTHESIS
  // the result slot is always free while a word is being examined
  a_check_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CHECK) |-> !out_tvalid_r)
    else $error("result register busy during word check");

  // an allocated block never lies in the management area
  a_alloc_above_fdb: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && out_found_r) |-> (out_block_r >= fdb_r))
    else $error("allocated block below first data block");

  // the map is only written by the clearing pass or at the end of a check
  a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> ((state_r == ST_CLEAR) || (state_r == ST_CHECK)))
    else $error("map write outside clear or check");

  // a result appears only at the end of a check or straight from an accepted item
  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_tvalid_r ##1 out_tvalid_r) |-> $past((state_r == ST_CHECK) || in_fire))
    else $error("result without a cause");
`endif

endmodule

@@ dv/bitmap_block_allocator_core_tb.sv @@
// Self-checking testbench for the first-fit bitmap block allocator core.
`timescale 1ns / 100ps

module bitmap_block_allocator_core_tb;
  import bba_pkg::*;

  localparam int HOLD_CYCLES  = 300;      // long output stall to back the block up
  localparam int DRAIN_CYCLES = 40;       // settle time once nothing is outstanding
  localparam int PAD_W        = 16 - BLOCK_W;

  typedef struct {
    logic [BLOCK_W-1:0] blk;
    logic               found;
    logic               is_free;
  } alloc_result_t;

  // Tracks the used map and first data block; predicts one result per item.
  class alloc_scoreboard;
    bit [BLOCK_SPAN-1:0] used_bits;
    logic [BLOCK_W-1:0]  first_blk;
    alloc_result_t       awaited[$];
    int                  errors;
    int                  n_items;
    int                  n_found;
    int                  n_full;
    int                  n_free_hits;

    function new();
      used_bits = '0;
      first_blk = BLOCK_W'(FDB_RESET);
    endfunction

    function void set_first_block(logic [BLOCK_W-1:0] v);
      first_blk = v;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function void note_input(opcode_t op, logic [BLOCK_W-1:0] blk);
      alloc_result_t r;
      r.blk     = blk;
      r.found   = 1'b0;
      r.is_free = 1'b0;
      n_items++;
      case (op)
        OP_ALLOC: begin
          r.blk = '0;
          for (int b = first_blk; b < BLOCK_SPAN; b++) begin
            if (!used_bits[b]) begin
              used_bits[b] = 1'b1;
              r.blk   = BLOCK_W'(b);
              r.found = 1'b1;
              break;
            end
          end
          if (r.found) n_found++;
          else n_full++;
        end
        OP_FREE: used_bits[blk] = 1'b0;
        OP_MARK: used_bits[blk] = 1'b1;
        default: begin
          r.is_free = !used_bits[blk];
          if (r.is_free) n_free_hits++;
        end
      endcase
      awaited.push_back(r);
    endfunction

    function void check_result(logic [15:0] tdata);
      alloc_result_t exp_r;
      if (awaited.size() == 0) begin
        $display("%0t: result with nothing outstanding, actual tdata 0x%04h", $time, tdata);
        errors++;
        return;
      end
      exp_r = awaited.pop_front();
      if (tdata[BLOCK_W-1:0] !== exp_r.blk) begin
        $display("%0t: result_block mismatch, expected %0d actual %0d",
                 $time, exp_r.blk, tdata[BLOCK_W-1:0]);
        errors++;
      end
      if (tdata[BLOCK_W] !== exp_r.found) begin
        $display("%0t: found mismatch, expected %0b actual %0b",
                 $time, exp_r.found, tdata[BLOCK_W]);
        errors++;
      end
      if (tdata[BLOCK_W+1] !== exp_r.is_free) begin
        $display("%0t: block_free mismatch, expected %0b actual %0b",
                 $time, exp_r.is_free, tdata[BLOCK_W+1]);
        errors++;
      end
      if (tdata[15:BLOCK_W+2] !== '0) begin
        $display("%0t: tdata padding mismatch, expected 0 actual 0x%0h",
                 $time, tdata[15:BLOCK_W+2]);
        errors++;
      end
    endfunction
  endclass

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               in_tvalid  = 1'b0;
  logic               in_tready;
  logic [15:0]        in_tdata   = '0;   // [9:0] block_number, rest zero
  logic [1:0]         in_tuser   = '0;   // [1:0] opcode
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [15:0]        out_tdata;         // [9:0] result_block, [10] found, [11] block_free
  logic               cfg_valid  = 1'b0;
  logic               cfg_ready;
  logic [BLOCK_W-1:0] cfg_data   = '0;

  bit tx_idle  = 1'b0;
  bit rx_idle  = 1'b0;
  bit hold_req = 1'b0;
  int n_cfg    = 0;

  alloc_scoreboard sb = new();

  bitmap_block_allocator_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // result side: random stalls, plus one long hold on request
  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
        out_tready <= 1'b1;
      end else if (rx_idle && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(0, 9)) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  task automatic send_item(opcode_t op, logic [BLOCK_W-1:0] blk);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {{PAD_W{1'b0}}, blk};
    do @(posedge clk); while (!in_tready);
    sb.note_input(op, blk);
  endtask

  task automatic sender_gap(int n);
    @(negedge clk);
    in_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic wait_drained();
    sender_gap(0);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_first_block(logic [BLOCK_W-1:0] v);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_first_block(v);
    n_cfg++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic opcode_t pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return OP_ALLOC;
    if (r < 60) return OP_FREE;
    if (r < 75) return OP_MARK;
    return OP_QUERY;
  endfunction

  // half the blocks land just above the first data block, where allocations sit
  function automatic logic [BLOCK_W-1:0] pick_block();
    int b;
    if ($urandom_range(0, 1) == 0) begin
      b = sb.first_blk + $urandom_range(0, 47);
      if (b > BLOCK_SPAN - 1) b = BLOCK_SPAN - 1;
    end else begin
      b = $urandom_range(0, BLOCK_SPAN - 1);
    end
    return BLOCK_W'(b);
  endfunction

  task automatic run_random(logic [BLOCK_W-1:0] fdb, int count, bit with_hold,
                            bit mid_pause);
    write_first_block(fdb);
    if (with_hold) hold_req = 1'b1;
    for (int i = 0; i < count; i++) begin
      send_item(pick_op(), pick_block());
      if (mid_pause && i == count / 2) wait_drained();
      else if (tx_idle && $urandom_range(0, 3) == 0) sender_gap($urandom_range(1, 10));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset first data block, every opcode, field extremes
    send_item(OP_ALLOC, '0);
    send_item(OP_ALLOC, '1);
    send_item(OP_QUERY, 10'd64);
    send_item(OP_QUERY, 10'd63);
    send_item(OP_QUERY, '0);
    send_item(OP_QUERY, '1);
    send_item(OP_MARK,  '1);
    send_item(OP_QUERY, '1);
    send_item(OP_MARK,  10'd66);
    send_item(OP_ALLOC, '0);
    send_item(OP_FREE,  10'd64);
    send_item(OP_ALLOC, 10'h2AA);
    send_item(OP_MARK,  '0);
    send_item(OP_QUERY, '0);
    send_item(OP_FREE,  '0);
    send_item(OP_QUERY, '0);
    send_item(OP_FREE,  10'h155);
    send_item(OP_QUERY, 10'h2AA);
    // first data block at the top: nothing left to hand out until it is freed
    write_first_block('1);
    send_item(OP_ALLOC, '0);
    send_item(OP_FREE,  '1);
    send_item(OP_ALLOC, '0);
    send_item(OP_ALLOC, '0);
    write_first_block('0);
    send_item(OP_ALLOC, '0);

    tx_idle = 1'b1;
    rx_idle = 1'b1;
    run_random(10'd0,    130, 1'b0, 1'b0);
    run_random(10'd1000, 130, 1'b1, 1'b0);
    tx_idle = 1'b0;
    run_random(BLOCK_W'($urandom_range(0, BLOCK_SPAN - 1)), 130, 1'b0, 1'b0);
    tx_idle = 1'b1;
    run_random(10'd512,  130, 1'b0, 1'b1);
    run_random(10'd1010, 130, 1'b0, 1'b0);
    run_random(10'd64,   130, 1'b0, 1'b0);
    // closing stretch at full rate on both sides
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    run_random(BLOCK_W'($urandom_range(0, BLOCK_SPAN - 1)), 120, 1'b0, 1'b0);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d items over %0d register writes: %0d allocations granted,",
             sb.n_items, n_cfg, sb.n_found);
    $display("  %0d allocations refused on a full range, %0d queries answered free.",
             sb.n_full, sb.n_free_hits);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
